// ===== rtl/length_framed_crc16_deframer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the length framed CRC-16 deframer
// Shared forms for the concurrent checks of the deframer modules.
// ----------------------------------------------------------------------------
`ifndef LENGTH_FRAMED_CRC16_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_FRAMED_CRC16_DEFRAMER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Deframer package
// Phase codes, the result word type and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package lfcd_pkg;

  localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [7:0]  MAX_LEN_RESET  = 8'd250;
  localparam logic [7:0]  MIN_FRAME_LEN  = 8'd3;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic {
    CFG_CRC_CHECK_ENABLE = 1'b0,
    CFG_MAX_FRAME_LENGTH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] frame_byte;
    logic [7:0] byte_position;
    logic       frame_end;
    logic       length_error;
    logic       crc_error;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lfcd_stream_if.sv =====
// ----------------------------------------------------------------------------
// Deframer stream interfaces
// Byte input channel and frame result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [7:0] byte_position;
  logic       frame_end;
  logic       length_error;
  logic       crc_error;

  modport source (output valid, output frame_byte, output byte_position,
                  output frame_end, output length_error, output crc_error,
                  input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input frame_end, input length_error, input crc_error,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/lfcd_parser.sv =====
// ----------------------------------------------------------------------------
// Deframer parser
// Flag hunt, length check, byte indexing and running CRC-16 for each frame.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_framed_crc16_deframer_core_macros.svh"

module lfcd_parser
  import lfcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  input  wire logic       crc_check_enable,
  input  wire logic [7:0] max_frame_length,
  output result_t         result
);

  phase_t      phase, phase_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  bytes_received, bytes_received_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_low, received_crc_low_next;

  logic        len_bad;
  logic [8:0]  pos_plus2;
  logic        in_payload;
  logic        at_crc_low;

  assign len_bad    = (rx_byte < MIN_FRAME_LEN) || (rx_byte > max_frame_length);
  assign pos_plus2  = {1'b0, bytes_received} + 9'd2;
  assign in_payload = pos_plus2 < {1'b0, frame_length};
  assign at_crc_low = pos_plus2 == {1'b0, frame_length};

  always_comb begin
    case (phase)
      PH_LEN:  phase_next = len_bad ? PH_HUNT : PH_BODY;
      PH_BODY: phase_next = (in_payload || at_crc_low) ? PH_BODY : PH_HUNT;
      default: phase_next = (rx_byte == FLAG_BYTE) ? PH_LEN : PH_HUNT;
    endcase
  end

  always_comb begin
    frame_length_next     = frame_length;
    bytes_received_next   = bytes_received;
    running_crc_next      = running_crc;
    received_crc_low_next = received_crc_low;
    result                = '0;
    result.frame_byte     = rx_byte;
    case (phase)
      PH_LEN: begin
        frame_length_next    = rx_byte;
        result.valid         = 1'b1;
        result.byte_position = 8'd0;
        if (len_bad) begin
          bytes_received_next = 8'd0;
          running_crc_next    = 16'h0000;
          result.frame_end    = 1'b1;
          result.length_error = 1'b1;
        end else begin
          bytes_received_next = 8'd1;
          running_crc_next    = crc16_byte(16'h0000, rx_byte);
        end
      end
      PH_BODY: begin
        bytes_received_next  = bytes_received + 8'd1;
        result.valid         = 1'b1;
        result.byte_position = bytes_received;
        if (in_payload) begin
          running_crc_next = crc16_byte(running_crc, rx_byte);
        end else if (at_crc_low) begin
          received_crc_low_next = rx_byte;
        end else begin
          result.frame_end = 1'b1;
          result.crc_error = crc_check_enable && ({rx_byte, received_crc_low} != running_crc);
        end
      end
      default: begin
        if (rx_byte == FLAG_BYTE) begin
          running_crc_next    = 16'h0000;
          bytes_received_next = 8'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      frame_length     <= 8'd0;
      bytes_received   <= 8'd0;
      running_crc      <= 16'h0000;
      received_crc_low <= 8'd0;
    end else if (accept) begin
      phase            <= phase_next;
      frame_length     <= frame_length_next;
      bytes_received   <= bytes_received_next;
      running_crc      <= running_crc_next;
      received_crc_low <= received_crc_low_next;
    end
  end

  `LFCD_ASSERT_SAME(a_len_err_form, clk, rst, result.valid && result.length_error,
    result.frame_end && !result.crc_error && (result.byte_position == 8'd0),
    "length error result is not a position zero frame end")
  `LFCD_ASSERT_NEXT(a_end_to_hunt, clk, rst, accept && result.valid && result.frame_end,
    phase == PH_HUNT, "parser did not return to hunting after frame end")
  `LFCD_ASSERT_NEXT(a_flag_to_len, clk, rst,
    accept && (phase != PH_LEN) && (phase != PH_BODY) && (rx_byte == FLAG_BYTE),
    phase == PH_LEN, "start flag did not lead to the length phase")
  `LFCD_ASSERT_SAME(a_hunt_silent, clk, rst, (phase != PH_LEN) && (phase != PH_BODY),
    !result.valid, "result produced while hunting")

endmodule

`default_nettype wire

// ===== rtl/length_framed_crc16_deframer_core.sv =====
// ----------------------------------------------------------------------------
// Length framed CRC-16 deframer
// A frame byte appears on the output in the cycle after it is taken.
// Throughput: one byte per cycle unless the output register is stalled; the
// parser state and eight-step CRC update sit before that output register.
// Reset: synchronous, clears the parser to flag hunting, empties the output
// register and restores crc_check_enable to 1 and max_frame_length to 250.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_framed_crc16_deframer_core_macros.svh"

module length_framed_crc16_deframer_core
  import lfcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  lfcd_in_if.sink         in,
  lfcd_out_if.source      out
);

  logic       crc_check_enable;
  logic [7:0] max_frame_length;
  logic       accept;
  result_t    result;
  logic       out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_check_enable <= 1'b1;
      max_frame_length <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_CRC_CHECK_ENABLE: crc_check_enable <= cfg_data[0];
        CFG_MAX_FRAME_LENGTH: max_frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in.ready = !out_valid || out.ready;
  assign accept   = in.valid && in.ready;

  lfcd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .rx_byte          (in.rx_byte),
    .crc_check_enable (crc_check_enable),
    .max_frame_length (max_frame_length),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= result.valid;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.valid) begin
      out.frame_byte    <= result.frame_byte;
      out.byte_position <= result.byte_position;
      out.frame_end     <= result.frame_end;
      out.length_error  <= result.length_error;
      out.crc_error     <= result.crc_error;
    end
  end

  assign out.valid = out_valid;

  `LFCD_ASSERT_SAME(a_stall_only_when_full, clk, rst, !in.ready,
    out.valid && !out.ready, "input stalled while the output register can move")
  `LFCD_ASSERT_NEXT(a_result_loaded, clk, rst, accept && result.valid,
    out.valid, "accepted result did not reach the output register")
  `LFCD_ASSERT_NEXT(a_held_when_stalled, clk, rst, out.valid && !out.ready,
    out.valid && $stable(out.frame_byte) && $stable(out.byte_position),
    "stalled output word changed")

endmodule

`default_nettype wire
